// ===== rtl/core/sldf_pkg.sv =====
// Shared types and constants for the sync/type/length deframer.
// No dependencies; sldf_core, sldf_outq, the top level and the testbench import this package.

package sldf_pkg;

    // Header layout: two sync bytes, one type byte, four length bytes (LSB first).
    localparam int unsigned HEADER_BYTES = 7;
    localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);
    // The final header byte is consumed live, so only the bytes before it are held.
    localparam int unsigned HDR_STORED   = HEADER_BYTES - 1;

    localparam logic [HDR_IDX_W-1:0] HDR_POS_SYNC0 = HDR_IDX_W'(0);
    localparam logic [HDR_IDX_W-1:0] HDR_POS_SYNC1 = HDR_IDX_W'(1);
    localparam logic [HDR_IDX_W-1:0] HDR_POS_TYPE  = HDR_IDX_W'(2);
    localparam logic [HDR_IDX_W-1:0] HDR_POS_LEN0  = HDR_IDX_W'(3);
    localparam logic [HDR_IDX_W-1:0] HDR_POS_LEN1  = HDR_IDX_W'(4);
    localparam logic [HDR_IDX_W-1:0] HDR_POS_LEN2  = HDR_IDX_W'(5);
    localparam logic [HDR_IDX_W-1:0] HDR_POS_LAST  = HDR_IDX_W'(HEADER_BYTES - 1);

    localparam int unsigned LEN_W = 32;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_EMPTY    = 2'd1,
        EV_SYNC_ERR = 2'd2
    } t_event;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] payload_byte;
        logic [7:0] frame_type;
        logic       last_byte;
    } t_result;

endpackage

// ===== rtl/core/sldf_byte_if.sv =====
// Input channel of the deframer: one received byte per word.
// No dependencies.

interface sldf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/sldf_res_if.sv =====
// Result channel of the deframer: event code, payload byte, frame type, last flag.
// No dependencies; event_res carries the codes of sldf_pkg::t_event.

interface sldf_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] frame_type;
    logic       last_byte;

    modport source (output valid, output event_res, output payload_byte,
                    output frame_type, output last_byte, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input frame_type, input last_byte, output ready);
endinterface

// ===== rtl/core/sync_length_frame_deframer_top.sv =====
// Top level of the sync/type/length deframer: configuration registers and module wiring.
// Depends on sldf_pkg, sldf_byte_if, sldf_res_if, sldf_core and sldf_outq.

// Takes one received byte per clock on i_byte and deframes it: a 7-byte header (two sync
// bytes, a type byte, a 32-bit little-endian length) followed by exactly that many payload
// bytes. Each payload byte leaves on o_res with its frame type, the final one with last_byte
// set; a zero-length frame gives one empty-frame result and a header whose sync bytes do not
// match the configured values gives one sync-error result. The deframing state updates at
// the accepting edge, where the result is written into a two-entry result queue.
// i_byte.ready is low only while that queue holds two results that the sink has not taken,
// so the sustained rate is one byte per clock as long as o_res.ready stays high. Sync values
// are written through i_cfg_we/i_cfg_idx/i_cfg_data (index 0 first sync byte, index 1 second)
// by the user only while no frame is in progress; the block itself does not enforce this.

module sync_length_frame_deframer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sldf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sldf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    sldf_byte_if.sink                           i_byte,
    sldf_res_if.source                          o_res
);
    import sldf_pkg::*;

    logic [7:0] r_sync_first, r_sync_second;
    logic       accept;
    logic       room;
    logic       res_valid;
    t_result    res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= '0;
            r_sync_second <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_byte.ready = room;
    assign accept       = i_byte.valid && room;

    sldf_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_byte.rx_byte),
        .i_sync_first  (r_sync_first),
        .i_sync_second (r_sync_second),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    sldf_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_data (res),
        .o_room      (room),
        .o_res       (o_res)
    );

endmodule

// ===== rtl/core/sldf_core.sv =====
// Deframing state: header collection, sync check, length load and payload countdown.
// Depends on sldf_pkg.

module sldf_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_sync_first,
    input  logic [7:0]        i_sync_second,
    output logic              o_res_valid,
    output sldf_pkg::t_result o_res
);
    import sldf_pkg::*;

    logic [HDR_IDX_W-1:0] r_hdr_idx, n_hdr_idx;
    logic                 r_in_payload, n_in_payload;
    logic [7:0]           r_type, n_type;
    logic [LEN_W-1:0]     r_left, n_left;
    logic [7:0]           r_store [HDR_STORED];

    logic [HDR_IDX_W-1:0] idx_eff;
    logic                 hdr_final;
    logic                 sync_ok;
    logic [LEN_W-1:0]     hdr_len;
    logic                 pay_last;

    // An out-of-range index restarts collection at the first header byte.
    assign idx_eff   = (r_hdr_idx > HDR_POS_LAST) ? '0 : r_hdr_idx;
    assign hdr_final = (idx_eff == HDR_POS_LAST);
    assign sync_ok   = (r_store[HDR_POS_SYNC0] == i_sync_first) &&
                       (r_store[HDR_POS_SYNC1] == i_sync_second);
    assign hdr_len   = {i_rx_byte, r_store[HDR_POS_LEN2], r_store[HDR_POS_LEN1],
                        r_store[HDR_POS_LEN0]};
    assign pay_last  = (r_left <= LEN_W'(1));

    always_comb begin
        n_hdr_idx            = r_hdr_idx;
        n_in_payload         = r_in_payload;
        n_type               = r_type;
        n_left               = r_left;
        o_res_valid          = 1'b0;
        o_res.event_res      = EV_PAYLOAD;
        o_res.payload_byte   = '0;
        o_res.frame_type     = '0;
        o_res.last_byte      = 1'b0;
        if (i_accept) begin
            if (r_in_payload) begin
                o_res_valid        = 1'b1;
                o_res.event_res    = EV_PAYLOAD;
                o_res.payload_byte = i_rx_byte;
                o_res.frame_type   = r_type;
                o_res.last_byte    = pay_last;
                n_left             = pay_last ? '0 : r_left - LEN_W'(1);
                n_in_payload       = !pay_last;
            end else if (!hdr_final) begin
                n_hdr_idx = idx_eff + HDR_IDX_W'(1);
            end else begin
                n_hdr_idx = '0;
                if (!sync_ok) begin
                    // drop the header, report once and hunt again
                    o_res_valid     = 1'b1;
                    o_res.event_res = EV_SYNC_ERR;
                end else begin
                    n_type = r_store[HDR_POS_TYPE];
                    if (hdr_len == '0) begin
                        o_res_valid      = 1'b1;
                        o_res.event_res  = EV_EMPTY;
                        o_res.frame_type = r_store[HDR_POS_TYPE];
                        o_res.last_byte  = 1'b1;
                        n_left           = '0;
                    end else begin
                        n_left       = hdr_len;
                        n_in_payload = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx    <= '0;
            r_in_payload <= 1'b0;
            r_type       <= '0;
            r_left       <= '0;
        end else begin
            r_hdr_idx    <= n_hdr_idx;
            r_in_payload <= n_in_payload;
            r_type       <= n_type;
            r_left       <= n_left;
        end
    end

    // Header bytes before the last one are held until the header is complete.
    always_ff @(posedge i_clk) begin
        if (i_accept && !r_in_payload && !hdr_final) begin
            r_store[idx_eff] <= i_rx_byte;
        end
    end

`ifndef SYNTH
    a_payload_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_left != '0))
        else $error("payload phase with zero bytes left");

    a_hdr_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_idx <= HDR_POS_LAST)
        else $error("header index out of range");

    a_payload_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_in_payload && pay_last) |=> !r_in_payload && (r_hdr_idx == '0))
        else $error("last payload byte did not return to header collection");
`endif

endmodule

// ===== rtl/core/sldf_outq.sv =====
// Two-entry result queue that decouples the deframing state from the result channel.
// Depends on sldf_pkg and sldf_res_if.

module sldf_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sldf_pkg::t_result i_push_data,
    output logic              o_room,
    sldf_res_if.source        o_res
);
    import sldf_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;
    t_result    head;

    assign pop    = o_res.valid && o_res.ready;
    assign o_room = (r_count != 2'd2);
    assign head   = r_mem[r_rd_ptr];

    assign o_res.valid        = (r_count != 2'd0);
    assign o_res.event_res    = head.event_res;
    assign o_res.payload_byte = head.payload_byte;
    assign o_res.frame_type   = head.frame_type;
    assign o_res.last_byte    = head.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("push into full result queue");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |=> o_res.valid)
        else $error("pushed result not presented");
`endif

endmodule

// ===== tb/tb_sync_length_frame_deframer_top.sv =====
// Self-checking testbench for sync_length_frame_deframer_top: random and directed byte streams
// under several sync settings, with results predicted in-bench and checked word by word.
// Depends on sldf_pkg, sldf_byte_if, sldf_res_if and the deframer RTL.

module tb_sync_length_frame_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sldf_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STALL_CYCLES  = 200;
    localparam int unsigned LONG_FRAME    = 257;
    localparam int unsigned OPEN_BODY     = 40;
    localparam int unsigned MAX_PRINTS    = 40;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sldf_byte_if byte_ch ();
    sldf_res_if  res_ch ();

    sync_length_frame_deframer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_byte     (byte_ch),
        .o_res      (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Bytes waiting for the driver and results waiting for the monitor.
    logic [7:0] pending_bytes[$];
    t_result    frame_results[$];

    // Deframer shadow state.
    logic [7:0]  sync_first  = '0;
    logic [7:0]  sync_second = '0;
    logic [2:0]  hdr_count   = '0;
    logic        in_body     = 1'b0;
    logic [7:0]  hdr_bytes [HEADER_BYTES];
    logic [7:0]  frame_kind  = '0;
    logic [31:0] body_left   = '0;

    int   gap_pct      = 37;
    int   hold_cycles  = 0;
    logic byte_fire    = 1'b0;
    int   bytes_queued = 0;
    int   bytes_taken  = 0;
    int   error_count  = 0;
    int   n_payload    = 0;
    int   n_empty      = 0;
    int   n_sync_err   = 0;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // Advance the shadow deframer by one received byte; queue the result it causes, if any.
    function automatic void deframe_byte(input logic [7:0] rx);
        t_result     res;
        logic [31:0] len;
        if (in_body) begin
            res.event_res    = EV_PAYLOAD;
            res.payload_byte = rx;
            res.frame_type   = frame_kind;
            res.last_byte    = (body_left <= 32'd1);
            if (res.last_byte) begin
                body_left = '0;
                in_body   = 1'b0;
            end else begin
                body_left = body_left - 32'd1;
            end
            frame_results.push_back(res);
            return;
        end
        if (hdr_count >= HEADER_BYTES) hdr_count = '0;
        hdr_bytes[hdr_count] = rx;
        hdr_count++;
        if (hdr_count < HEADER_BYTES) return;

        hdr_count = '0;
        if (hdr_bytes[HDR_POS_SYNC0] != sync_first ||
            hdr_bytes[HDR_POS_SYNC1] != sync_second) begin
            res.event_res    = EV_SYNC_ERR;
            res.payload_byte = '0;
            res.frame_type   = '0;
            res.last_byte    = 1'b0;
            frame_results.push_back(res);
            return;
        end
        frame_kind = hdr_bytes[HDR_POS_TYPE];
        len = {hdr_bytes[HDR_POS_LAST], hdr_bytes[HDR_POS_LEN2],
               hdr_bytes[HDR_POS_LEN1], hdr_bytes[HDR_POS_LEN0]};
        if (len == '0) begin
            body_left        = '0;
            res.event_res    = EV_EMPTY;
            res.payload_byte = '0;
            res.frame_type   = frame_kind;
            res.last_byte    = 1'b1;
            frame_results.push_back(res);
            return;
        end
        body_left = len;
        in_body   = 1'b1;
    endfunction

    task automatic push_byte(input logic [7:0] value);
        pending_bytes.push_back(value);
        bytes_queued++;
    endtask

    task automatic queue_header(input logic [7:0] s0, input logic [7:0] s1,
                                input logic [7:0] kind, input logic [31:0] len);
        push_byte(s0);
        push_byte(s1);
        push_byte(kind);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        push_byte(len[23:16]);
        push_byte(len[31:24]);
    endtask

    task automatic queue_frame(input logic [7:0] kind, input int len);
        queue_header(sync_first, sync_second, kind, 32'(len));
        repeat (len) push_byte(8'($urandom));
    endtask

    // Mostly well-formed frames, some empty frames, the rest headers with bad sync.
    task automatic queue_random_traffic(input int target);
        int start;
        int pick;
        start = bytes_queued;
        while (bytes_queued - start < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                queue_frame(8'($urandom),
                            ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12));
            end else if (pick < 80) begin
                queue_header(sync_first, sync_second, 8'($urandom), 32'd0);
            end else begin
                // corrupt the first sync byte, the second, or both
                pick = $urandom_range(2);
                queue_header((pick != 1) ? sync_first ^ 8'($urandom_range(1, 255)) : sync_first,
                             (pick != 0) ? sync_second ^ 8'($urandom_range(1, 255)) : sync_second,
                             8'($urandom), 32'($urandom));
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST:  sync_first  = value;
            CFG_SYNC_SECOND: sync_second = value;
            default: ;
        endcase
    endtask

    // Hold until every byte is taken and every result is back, then let the pipe settle.
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || frame_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [7:0] s0, input logic [7:0] s1, input int pct,
                             input int target, input bit stall, input bit long_frame);
        write_reg(CFG_SYNC_FIRST, s0);
        write_reg(CFG_SYNC_SECOND, s1);
        gap_pct = pct;
        queue_random_traffic(target);
        if (long_frame) queue_frame(8'($urandom), LONG_FRAME);
        if (stall) begin
            @(posedge i_clk);
            hold_cycles = STALL_CYCLES;
        end
        wait_drained();
    endtask

    // Byte driver: advance only after the current word was taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else if (!byte_ch.valid || byte_fire) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= gap_pct) begin
                byte_ch.valid   <= 1'b1;
                byte_ch.rx_byte <= pending_bytes.pop_front();
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    always @(negedge i_clk) begin
        res_ch.ready <= (hold_cycles == 0) && ($urandom_range(99) >= gap_pct);
    end

    // Monitor: check each taken result against the oldest prediction, predict on each taken byte.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            byte_fire <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (frame_results.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result event=%0d byte=%02h type=%02h last=%0b",
                        res_ch.event_res, res_ch.payload_byte,
                        res_ch.frame_type, res_ch.last_byte));
                end else begin
                    want = frame_results.pop_front();
                    case (want.event_res)
                        EV_PAYLOAD: n_payload++;
                        EV_EMPTY:   n_empty++;
                        default:    n_sync_err++;
                    endcase
                    if (res_ch.event_res !== want.event_res)
                        report_mismatch($sformatf("event_res %0d, want %0d",
                                                  res_ch.event_res, want.event_res));
                    if (res_ch.payload_byte !== want.payload_byte)
                        report_mismatch($sformatf("payload_byte %02h, want %02h",
                                                  res_ch.payload_byte, want.payload_byte));
                    if (res_ch.frame_type !== want.frame_type)
                        report_mismatch($sformatf("frame_type %02h, want %02h",
                                                  res_ch.frame_type, want.frame_type));
                    if (res_ch.last_byte !== want.last_byte)
                        report_mismatch($sformatf("last_byte %0b, want %0b",
                                                  res_ch.last_byte, want.last_byte));
                end
            end
            if (byte_ch.valid && byte_ch.ready) begin
                deframe_byte(byte_ch.rx_byte);
                bytes_taken++;
            end
            byte_fire <= byte_ch.valid && byte_ch.ready;
        end
    end

    initial begin
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = '0;
        res_ch.ready    = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one-byte frame, empty frame, bad second sync byte.
        write_reg(CFG_SYNC_FIRST, 8'hFF);
        write_reg(CFG_SYNC_SECOND, 8'h00);
        queue_header(sync_first, sync_second, 8'hFF, 32'd1);
        push_byte(8'h00);
        queue_header(sync_first, sync_second, 8'h00, 32'd0);
        queue_header(sync_first, 8'hFF, 8'h5A, 32'd0);
        wait_drained();

        run_phase(8'h00, 8'h00, 37, 110, 1'b0, 1'b0);
        run_phase(8'hFF, 8'hFF, 37, 110, 1'b1, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 0, 110, 1'b0, 1'b0);
        run_phase(8'hA5, 8'h5A, 37, 110, 1'b0, 1'b1);

        // Leave a frame open with the largest length; no result is ever marked last here.
        queue_header(sync_first, sync_second, 8'($urandom), 32'hFFFF_FFFF);
        repeat (OPEN_BODY) push_byte(8'($urandom));
        wait_drained();

        if (frame_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", frame_results.size()));

        $display("Summary: %0d bytes over five sync settings; %0d payload bytes,",
                 bytes_taken, n_payload);
        $display("Summary: %0d empty frames, %0d sync errors; a %0d-cycle result stall,",
                 n_empty, n_sync_err, STALL_CYCLES);
        $display("Summary: a %0d-byte frame and an open max-length frame.", LONG_FRAME);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/sldf_pkg.sv
rtl/core/sldf_byte_if.sv
rtl/core/sldf_res_if.sv
rtl/core/sldf_core.sv
rtl/core/sldf_outq.sv
rtl/core/sync_length_frame_deframer_top.sv
tb/tb_sync_length_frame_deframer_top.sv
